>>> design/lco_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and controller/datapath types for the line clipper.
// Used by the interfaces, controller, datapath, top level and testbench; depends on nothing.
package lco_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int MAX_PASSES  = 16;
    localparam int PASS_W      = $clog2(MAX_PASSES + 1);
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN = 2'd0,
        CFG_Y_MIN = 2'd1,
        CFG_X_MAX = 2'd2,
        CFG_Y_MAX = 2'd3
    } t_cfg_idx;

    localparam logic [3:0] CODE_LEFT  = 4'h1;
    localparam logic [3:0] CODE_RIGHT = 4'h2;
    localparam logic [3:0] CODE_BELOW = 4'h4;
    localparam logic [3:0] CODE_ABOVE = 4'h8;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div_step;
        logic update;
        logic out_load;
        logic accept_flag;
    } t_dp_cmd;

    typedef struct packed {
        logic in_window;
        logic reject;
    } t_dp_status;

endpackage

>>> design/lco_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for segments, results and register writes.
// Depends on lco_pkg for default widths.
interface lco_seg_if #(parameter int W = lco_pkg::COORD_WIDTH);
    logic         valid;
    logic         ready;
    logic [W-1:0] x_start;
    logic [W-1:0] y_start;
    logic [W-1:0] x_end;
    logic [W-1:0] y_end;
    modport source (output valid, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lco_res_if #(parameter int W = lco_pkg::COORD_WIDTH);
    logic         valid;
    logic         ready;
    logic         accepted;
    logic [W-1:0] clip_x_start;
    logic [W-1:0] clip_y_start;
    logic [W-1:0] clip_x_end;
    logic [W-1:0] clip_y_end;
    modport source (output valid, accepted, clip_x_start, clip_y_start, clip_x_end,
                    clip_y_end, input ready);
    modport sink   (input valid, accepted, clip_x_start, clip_y_start, clip_x_end,
                    clip_y_end, output ready);
endinterface

interface lco_cfg_if #(parameter int W = lco_pkg::COORD_WIDTH);
    logic                           valid;
    logic                           ready;
    logic [lco_pkg::CFG_IDX_W-1:0]  index;
    logic [W-1:0]                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/lco_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the line clipper: sequences tests, clip passes and output.
// Depends on lco_pkg for command and status types.
module lco_ctrl #(
    parameter int COORD_WIDTH = lco_pkg::COORD_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  lco_pkg::t_dp_status i_status,
    output lco_pkg::t_dp_cmd    o_cmd
);

    localparam int DIV_STEPS = 2 * COORD_WIDTH;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE, S_TEST, S_MUL, S_DIV, S_UPD, S_DONE
    } t_state;

    t_state                       r_state;
    logic [lco_pkg::PASS_W-1:0]   r_pass;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_acc;
    logic                         r_out_valid;
    logic                         w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd             = '0;
        o_cmd.accept_flag = r_acc;
        unique case (r_state)
            S_IDLE: o_cmd.load     = i_in_valid;
            S_TEST: o_cmd.setup    = !i_status.in_window && !i_status.reject &&
                                     (r_pass != lco_pkg::PASS_W'(lco_pkg::MAX_PASSES));
            S_MUL:  o_cmd.mul      = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_UPD:  o_cmd.update   = 1'b1;
            S_DONE: o_cmd.out_load = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= '0;
            r_cnt       <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pass  <= '0;
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (i_status.in_window) begin
                        r_acc   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (i_status.reject ||
                                 r_pass == lco_pkg::PASS_W'(lco_pkg::MAX_PASSES)) begin
                        r_acc   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_UPD;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_UPD: begin
                    r_pass  <= r_pass + lco_pkg::PASS_W'(1);
                    r_state <= S_TEST;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/lco_dp.sv
`timescale 1ns / 1ps
// Datapath for the line clipper: window registers, endpoints, outcodes, multiplier,
// bit-serial divider and output registers. Depends on lco_pkg.
module lco_dp #(
    parameter int W = lco_pkg::COORD_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lco_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [W-1:0]               i_cfg_data,
    input  logic [W-1:0]               i_x_start,
    input  logic [W-1:0]               i_y_start,
    input  logic [W-1:0]               i_x_end,
    input  logic [W-1:0]               i_y_end,
    input  lco_pkg::t_dp_cmd           i_cmd,
    output lco_pkg::t_dp_status        o_status,
    output logic                       o_accepted,
    output logic [W-1:0]               o_x_start,
    output logic [W-1:0]               o_y_start,
    output logic [W-1:0]               o_x_end,
    output logic [W-1:0]               o_y_end
);

    logic signed [W-1:0] r_x_min, r_y_min, r_x_max, r_y_max;
    logic signed [W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [W-1:0]        r_mag_a, r_mag_b, r_mag_d;
    logic                r_neg, r_horiz, r_first;
    logic [W-1:0]        r_base, r_edge;
    logic [2*W-1:0]      r_prod;
    logic [W-1:0]        r_rem, r_quo;
    logic                r_accepted;
    logic [W-1:0]        r_ox0, r_oy0, r_ox1, r_oy1;

    logic [3:0]          w_c0, w_c1, w_co;
    logic signed [W:0]   w_delta, w_num, w_den;
    logic [W-1:0]        w_base, w_edge;
    logic                w_horiz;
    logic [W:0]          w_rem_sh;
    logic                w_ge;
    logic [W-1:0]        w_q, w_off, w_val;

    function automatic logic [3:0] outcode(logic signed [W-1:0] x, logic signed [W-1:0] y,
                                           logic signed [W-1:0] xl, logic signed [W-1:0] xh,
                                           logic signed [W-1:0] yl, logic signed [W-1:0] yh);
        logic [3:0] c;
        c = 4'h0;
        if (x < xl) begin
            c = c | lco_pkg::CODE_LEFT;
        end else if (x > xh) begin
            c = c | lco_pkg::CODE_RIGHT;
        end
        if (y < yl) begin
            c = c | lco_pkg::CODE_BELOW;
        end else if (y > yh) begin
            c = c | lco_pkg::CODE_ABOVE;
        end
        return c;
    endfunction

    function automatic logic [W-1:0] mag(logic signed [W:0] v);
        logic signed [W:0] a;
        a = v[W] ? -v : v;
        return a[W-1:0];
    endfunction

    function automatic logic signed [W:0] sdiff(logic signed [W-1:0] a,
                                                logic signed [W-1:0] b);
        return {a[W-1], a} - {b[W-1], b};
    endfunction

    assign w_c0               = outcode(r_x0, r_y0, r_x_min, r_x_max, r_y_min, r_y_max);
    assign w_c1               = outcode(r_x1, r_y1, r_x_min, r_x_max, r_y_min, r_y_max);
    assign o_status.in_window = ((w_c0 | w_c1) == 4'h0);
    assign o_status.reject    = ((w_c0 & w_c1) != 4'h0);
    assign w_co               = (w_c0 != 4'h0) ? w_c0 : w_c1;

    always_comb begin
        if ((w_co & lco_pkg::CODE_ABOVE) != 4'h0) begin
            w_delta = sdiff(r_x1, r_x0);
            w_num   = sdiff(r_y_max, r_y0);
            w_den   = sdiff(r_y1, r_y0);
            w_base  = r_x0;
            w_edge  = r_y_max;
            w_horiz = 1'b1;
        end else if ((w_co & lco_pkg::CODE_BELOW) != 4'h0) begin
            w_delta = sdiff(r_x1, r_x0);
            w_num   = sdiff(r_y_min, r_y0);
            w_den   = sdiff(r_y1, r_y0);
            w_base  = r_x0;
            w_edge  = r_y_min;
            w_horiz = 1'b1;
        end else if ((w_co & lco_pkg::CODE_RIGHT) != 4'h0) begin
            w_delta = sdiff(r_y1, r_y0);
            w_num   = sdiff(r_x_max, r_x0);
            w_den   = sdiff(r_x1, r_x0);
            w_base  = r_y0;
            w_edge  = r_x_max;
            w_horiz = 1'b0;
        end else begin
            w_delta = sdiff(r_y1, r_y0);
            w_num   = sdiff(r_x_min, r_x0);
            w_den   = sdiff(r_x1, r_x0);
            w_base  = r_y0;
            w_edge  = r_x_min;
            w_horiz = 1'b0;
        end
    end

    assign w_rem_sh = {r_rem, r_prod[2*W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_mag_d});
    assign w_q      = (r_mag_d == '0) ? '0 : r_quo;
    assign w_off    = r_neg ? -w_q : w_q;
    assign w_val    = r_base + w_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= '0;
            r_y_min <= '0;
            r_x_max <= '0;
            r_y_max <= '0;
        end else if (i_cfg_we) begin
            unique case (lco_pkg::t_cfg_idx'(i_cfg_index))
                lco_pkg::CFG_X_MIN: r_x_min <= i_cfg_data;
                lco_pkg::CFG_Y_MIN: r_y_min <= i_cfg_data;
                lco_pkg::CFG_X_MAX: r_x_max <= i_cfg_data;
                lco_pkg::CFG_Y_MAX: r_y_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0 <= i_x_start;
            r_y0 <= i_y_start;
            r_x1 <= i_x_end;
            r_y1 <= i_y_end;
        end else if (i_cmd.update) begin
            if (r_first) begin
                r_x0 <= r_horiz ? w_val : r_edge;
                r_y0 <= r_horiz ? r_edge : w_val;
            end else begin
                r_x1 <= r_horiz ? w_val : r_edge;
                r_y1 <= r_horiz ? r_edge : w_val;
            end
        end
        if (i_cmd.setup) begin
            r_mag_a <= mag(w_delta);
            r_mag_b <= mag(w_num);
            r_mag_d <= mag(w_den);
            r_neg   <= w_delta[W] ^ w_num[W] ^ w_den[W];
            r_base  <= w_base;
            r_edge  <= w_edge;
            r_horiz <= w_horiz;
            r_first <= (w_c0 != 4'h0);
        end
        if (i_cmd.mul) begin
            r_prod <= r_mag_a * r_mag_b;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            r_prod <= {r_prod[2*W-2:0], 1'b0};
            r_rem  <= w_ge ? W'(w_rem_sh - {1'b0, r_mag_d}) : w_rem_sh[W-1:0];
            r_quo  <= {r_quo[W-2:0], w_ge};
        end
        if (i_cmd.out_load) begin
            r_accepted <= i_cmd.accept_flag;
            r_ox0      <= r_x0;
            r_oy0      <= r_y0;
            r_ox1      <= r_x1;
            r_oy1      <= r_y1;
        end
    end

    assign o_accepted = r_accepted;
    assign o_x_start  = r_ox0;
    assign o_y_start  = r_oy0;
    assign o_x_end    = r_ox1;
    assign o_y_end    = r_oy1;

endmodule

>>> design/line_clip_outcode.sv
`timescale 1ns / 1ps
// A segment needing no clip pass goes from the test state to the done state, where the result
// is registered; each clip pass runs the test, multiply, bit-serial divide and update states.
// At most 16 passes. One segment at a time: a new segment is taken only once the controller
// returns to idle, which it does as the result is registered; a stalled output holds it in done.
// Reset: window registers clear to zero, controller returns to idle, no result valid.
module line_clip_outcode #(
    parameter int COORD_WIDTH = lco_pkg::COORD_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lco_seg_if.sink    i_seg,
    lco_cfg_if.sink    i_cfg,
    lco_res_if.source  o_res
);

    lco_pkg::t_dp_cmd    w_cmd;
    lco_pkg::t_dp_status w_status;

    assign i_cfg.ready = 1'b1;

    lco_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_seg.valid),
        .o_in_ready  (i_seg.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lco_dp #(.W(COORD_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_x_start   (i_seg.x_start),
        .i_y_start   (i_seg.y_start),
        .i_x_end     (i_seg.x_end),
        .i_y_end     (i_seg.y_end),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_accepted  (o_res.accepted),
        .o_x_start   (o_res.clip_x_start),
        .o_y_start   (o_res.clip_y_start),
        .o_x_end     (o_res.clip_x_end),
        .o_y_end     (o_res.clip_y_end)
    );

endmodule

>>> design/lco_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the line clipper and the bind that attaches them.
// Depends on line_clip_outcode.
module lco_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_seg_valid,
    input logic i_seg_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_cfg_ready
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("Result withdrawn before its transfer.");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seg_valid && i_seg_ready |=> !i_seg_ready)
        else $error("Segment taken while the previous one is still in work.");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seg_valid && i_seg_ready |=> !$rose(i_res_valid))
        else $error("Result appeared too soon after a segment transfer.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid && !$past(i_res_valid && i_rst_n))
        else $error("Result valid after reset.");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("Register write port not ready.");

endmodule

bind line_clip_outcode lco_checker u_lco_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_seg_valid (i_seg.valid),
    .i_seg_ready (i_seg.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_cfg_ready (i_cfg.ready)
);

>>> dv/tb_line_clip_outcode.sv
`timescale 1ns / 1ps
// Testbench for line_clip_outcode: drives segments and window writes, predicts each clipped
// segment with its own Cohen-Sutherland predictor and checks every result transfer.
// Depends on lco_pkg, the lco_*_if interfaces and the line_clip_outcode RTL.
module tb_line_clip_outcode;

    localparam int W = lco_pkg::COORD_WIDTH;
    localparam int LIMIT = 4000000;

    typedef struct {
        logic         acc;
        logic [W-1:0] xs, ys, xe, ye;
    } t_clip_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   errors = 0;
    int   src_idle = 0;
    int   snk_stall = 0;
    bit   hold_off = 1'b0;
    int   n_acc = 0;
    int   n_rej = 0;

    always #6 i_clk = ~i_clk;

    lco_seg_if #(W) seg ();
    lco_res_if #(W) res ();
    lco_cfg_if #(W) cfg ();

    line_clip_outcode #(.COORD_WIDTH(W)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg.sink),
        .i_cfg  (cfg.sink),
        .o_res  (res.source)
    );

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    class clip_board;
        longint    wx_min, wy_min, wx_max, wy_max;
        t_clip_res pending[$];

        function new();
            wx_min = 0;
            wy_min = 0;
            wx_max = 0;
            wy_max = 0;
        endfunction

        function void set_edge(lco_pkg::t_cfg_idx idx, logic [W-1:0] v);
            case (idx)
                lco_pkg::CFG_X_MIN: wx_min = longint'($signed(v));
                lco_pkg::CFG_Y_MIN: wy_min = longint'($signed(v));
                lco_pkg::CFG_X_MAX: wx_max = longint'($signed(v));
                default:            wy_max = longint'($signed(v));
            endcase
        endfunction

        function logic [3:0] outcode(longint x, longint y);
            logic [3:0] c;
            c = 4'h0;
            if (x < wx_min) c |= lco_pkg::CODE_LEFT;
            else if (x > wx_max) c |= lco_pkg::CODE_RIGHT;
            if (y < wy_min) c |= lco_pkg::CODE_BELOW;
            else if (y > wy_max) c |= lco_pkg::CODE_ABOVE;
            return c;
        endfunction

        function longint wrap(longint v);
            logic [W-1:0] b;
            b = v[W-1:0];
            return longint'($signed(b));
        endfunction

        // Quotient magnitude is kept to the coordinate width before the sign is applied.
        function longint interp(longint d, longint n, longint q);
            longint m;
            bit     neg;
            if (q == 0) return 0;
            neg = (d < 0) ^ (n < 0) ^ (q < 0);
            m = ((d < 0 ? -d : d) * (n < 0 ? -n : n)) / (q < 0 ? -q : q);
            m = m & ((64'sd1 <<< W) - 1);
            return neg ? -m : m;
        endfunction

        function void note_segment(logic [W-1:0] xs, ys, xe, ye);
            longint     x0, y0, x1, y1, x, y;
            logic [3:0] c0, c1, co;
            t_clip_res  r;
            r.acc = 1'b0;
            x0 = longint'($signed(xs));
            y0 = longint'($signed(ys));
            x1 = longint'($signed(xe));
            y1 = longint'($signed(ye));
            c0 = outcode(x0, y0);
            c1 = outcode(x1, y1);
            for (int p = 0; p <= lco_pkg::MAX_PASSES; p++) begin
                if ((c0 | c1) == 0) begin
                    r.acc = 1'b1;
                    break;
                end
                if ((c0 & c1) != 0 || p == lco_pkg::MAX_PASSES) break;
                co = (c0 != 0) ? c0 : c1;
                if (co & lco_pkg::CODE_ABOVE) begin
                    x = x0 + interp(x1 - x0, wy_max - y0, y1 - y0);
                    y = wy_max;
                end else if (co & lco_pkg::CODE_BELOW) begin
                    x = x0 + interp(x1 - x0, wy_min - y0, y1 - y0);
                    y = wy_min;
                end else if (co & lco_pkg::CODE_RIGHT) begin
                    y = y0 + interp(y1 - y0, wx_max - x0, x1 - x0);
                    x = wx_max;
                end else begin
                    y = y0 + interp(y1 - y0, wx_min - x0, x1 - x0);
                    x = wx_min;
                end
                x = wrap(x);
                y = wrap(y);
                if (c0 != 0) begin
                    x0 = x; y0 = y; c0 = outcode(x0, y0);
                end else begin
                    x1 = x; y1 = y; c1 = outcode(x1, y1);
                end
            end
            r.xs = x0[W-1:0];
            r.ys = y0[W-1:0];
            r.xe = x1[W-1:0];
            r.ye = y1[W-1:0];
            pending.push_back(r);
        endfunction

        task check_result(t_clip_res got);
            t_clip_res w;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (w.acc) n_acc++; else n_rej++;
            if (got.acc !== w.acc) report("accepted", got.acc, w.acc);
            if (got.xs !== w.xs) report("clip_x_start", $signed(got.xs), $signed(w.xs));
            if (got.ys !== w.ys) report("clip_y_start", $signed(got.ys), $signed(w.ys));
            if (got.xe !== w.xe) report("clip_x_end", $signed(got.xe), $signed(w.xe));
            if (got.ye !== w.ye) report("clip_y_end", $signed(got.ye), $signed(w.ye));
        endtask
    endclass

    clip_board board = new();

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("line_clip_outcode test failed");
            $finish;
        end
    end

    // Result side: stall pattern and the long hold-off, plus checking at each transfer.
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        t_clip_res got;
        if (i_rst_n && res.valid && res.ready) begin
            got.acc = res.accepted;
            got.xs = res.clip_x_start;
            got.ys = res.clip_y_start;
            got.xe = res.clip_x_end;
            got.ye = res.clip_y_end;
            board.check_result(got);
        end
        if (hold_off && hold_cnt < 600) begin
            hold_cnt <= hold_cnt + 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= snk_stall);
        end
    end

    task automatic write_edge(lco_pkg::t_cfg_idx idx, logic [W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= v;
        do @(posedge i_clk); while (!cfg.ready);
        board.set_edge(idx, v);
    endtask

    task automatic set_window(logic [W-1:0] xl, yl, xh, yh);
        write_edge(lco_pkg::CFG_X_MIN, xl);
        write_edge(lco_pkg::CFG_Y_MIN, yl);
        write_edge(lco_pkg::CFG_X_MAX, xh);
        write_edge(lco_pkg::CFG_Y_MAX, yh);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_segment(logic [W-1:0] xs, ys, xe, ye);
        while ($urandom_range(99) < src_idle) begin
            seg.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg.valid <= 1'b1;
        seg.x_start <= xs;
        seg.y_start <= ys;
        seg.x_end <= xe;
        seg.y_end <= ye;
        do @(posedge i_clk); while (!seg.ready);
        board.note_segment(xs, ys, xe, ye);
    endtask

    task automatic drain();
        seg.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [W-1:0] rnd_coord(longint lo, longint hi);
        longint v;
        v = lo + longint'($urandom_range(32'(hi - lo)));
        return v[W-1:0];
    endfunction

    // Endpoint mostly near the window so that clip passes happen; sometimes anywhere.
    function automatic logic [W-1:0] near(longint lo, longint hi);
        longint a, b;
        if ($urandom_range(9) == 0) return W'($urandom);
        a = (lo - 3000 < -32768) ? -32768 : lo - 3000;
        b = (hi + 3000 > 32767) ? 32767 : hi + 3000;
        if (a > b) return W'($urandom);
        return rnd_coord(a, b);
    endfunction

    task automatic random_batch(int n);
        for (int i = 0; i < n; i++) begin
            send_segment(near(board.wx_min, board.wx_max), near(board.wy_min, board.wy_max),
                         near(board.wx_min, board.wx_max), near(board.wy_min, board.wy_max));
        end
    endtask

    task automatic random_window();
        longint a, b, c, d;
        a = longint'($signed(16'($urandom)));
        b = longint'($signed(16'($urandom)));
        c = longint'($signed(16'($urandom)));
        d = longint'($signed(16'($urandom)));
        if ($urandom_range(7) != 0) begin
            if (a > b) begin a = a + b; b = a - b; a = a - b; end
            if (c > d) begin c = c + d; d = c - d; c = c - d; end
        end
        set_window(a[W-1:0], c[W-1:0], b[W-1:0], d[W-1:0]);
    endtask

    initial begin
        seg.valid = 1'b0;
        seg.x_start = '0;
        seg.y_start = '0;
        seg.x_end = '0;
        seg.y_end = '0;
        cfg.valid = 1'b0;
        cfg.index = lco_pkg::CFG_X_MIN;
        cfg.data = '0;
        res.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset window (single point), then a normal window.
        send_segment(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        drain();
        set_window(-16'sd100, -16'sd50, 16'sd100, 16'sd50);
        send_segment(16'sd0, 16'sd0, 16'sd10, 16'sd10);
        send_segment(-16'sd200, 16'sd0, 16'sd200, 16'sd0);
        send_segment(16'sd0, -16'sd300, 16'sd0, 16'sd300);
        send_segment(-16'sd200, -16'sd200, -16'sd150, 16'sd200);
        send_segment(16'sd150, 16'sd60, 16'sd300, 16'sd70);
        send_segment(-16'sd300, -16'sd90, 16'sd320, 16'sd95);
        send_segment(-16'sd150, 16'sd0, 16'sd0, 16'sd120);
        send_segment(16'sd0, 16'sd0, 16'sh7fff, 16'sh8000);
        send_segment(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_segment(16'sd100, 16'sd50, -16'sd100, -16'sd50);
        drain();
        set_window(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_segment(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_segment(16'sh1234, -16'sd5, 16'sd7, 16'shedcb);
        drain();
        // Inverted window: every point lies outside.
        set_window(16'sd100, 16'sd100, -16'sd100, -16'sd100);
        send_segment(16'sd0, 16'sd0, 16'sd5, 16'sd5);
        send_segment(-16'sd300, 16'sd20, 16'sd300, -16'sd20);
        send_segment(16'sd150, -16'sd150, -16'sd150, 16'sd150);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 77; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 77; end
                default: begin src_idle = 22; snk_stall = 22; end
            endcase
            random_window();
            if (ph == 5) hold_off = 1'b1;
            random_batch(68);
            hold_off = 1'b0;
            drain();
        end
        $display("Covered %0d accepted and %0d rejected segments over 16 random windows,",
                 n_acc, n_rej);
        $display("plus directed edge, extreme and inverted-window cases.");
        if (errors == 0) begin
            $display("line_clip_outcode test passed");
        end else begin
            $display("line_clip_outcode test failed");
        end
        $finish;
    end
endmodule
